[src/pcl_esc_pkg.sv]
package pcl_esc_pkg;

  localparam int unsigned CMD_BUF_SIZE = 100;
  localparam int unsigned CMD_LEN_W    = $clog2(CMD_BUF_SIZE);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned EV_W   = 5;
  localparam int unsigned ARG_W  = 32;
  localparam int unsigned ACC_W  = ARG_W + 4;

  // Parser mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_CMD  = 3'b010,
    MODE_DATA = 3'b100
  } mode_e;

  // Number phase codes
  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  typedef struct packed {
    logic       dead;
    logic [1:0] phase;
    logic       neg;
  } num_flags_t;

  // Event codes
  localparam logic [EV_W-1:0] EV_PLANE_HDR   = 5'd0;
  localparam logic [EV_W-1:0] EV_ROW_HDR     = 5'd1;
  localparam logic [EV_W-1:0] EV_SEED_RESET  = 5'd2;
  localparam logic [EV_W-1:0] EV_VMOVE_UNSUP = 5'd3;
  localparam logic [EV_W-1:0] EV_GOTO_LINE   = 5'd4;
  localparam logic [EV_W-1:0] EV_RESET       = 5'd5;
  localparam logic [EV_W-1:0] EV_UEL         = 5'd6;
  localparam logic [EV_W-1:0] EV_IMG_CFG     = 5'd7;
  localparam logic [EV_W-1:0] EV_RASTER_CFG  = 5'd8;
  localparam logic [EV_W-1:0] EV_MEDIA_SIZE  = 5'd9;
  localparam logic [EV_W-1:0] EV_START_RAST  = 5'd10;
  localparam logic [EV_W-1:0] EV_PRELOAD     = 5'd11;
  localparam logic [EV_W-1:0] EV_MEDIA_TYPE  = 5'd12;
  localparam logic [EV_W-1:0] EV_QUALITY     = 5'd13;
  localparam logic [EV_W-1:0] EV_XRES        = 5'd14;
  localparam logic [EV_W-1:0] EV_PIX_ROW     = 5'd15;
  localparam logic [EV_W-1:0] EV_END_RASTER  = 5'd16;
  localparam logic [EV_W-1:0] EV_DATA_BYTE   = 5'd17;

  // Characters
  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1b;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_HT    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_PLUS  = "+";
  localparam logic [BYTE_W-1:0] CH_MINUS = "-";
  localparam logic [BYTE_W-1:0] CH_ZERO  = "0";
  localparam logic [BYTE_W-1:0] CH_NINE  = "9";
  localparam logic [BYTE_W-1:0] CH_A     = "A";
  localparam logic [BYTE_W-1:0] CH_C     = "C";
  localparam logic [BYTE_W-1:0] CH_D     = "D";
  localparam logic [BYTE_W-1:0] CH_E     = "E";
  localparam logic [BYTE_W-1:0] CH_H     = "H";
  localparam logic [BYTE_W-1:0] CH_M     = "M";
  localparam logic [BYTE_W-1:0] CH_S     = "S";
  localparam logic [BYTE_W-1:0] CH_V     = "V";
  localparam logic [BYTE_W-1:0] CH_W     = "W";
  localparam logic [BYTE_W-1:0] CH_X     = "X";
  localparam logic [BYTE_W-1:0] CH_Y     = "Y";
  localparam logic [BYTE_W-1:0] CH_LC_B  = "b";

  // Two-character prefixes
  localparam logic [15:0] PFX_SB = "*b";
  localparam logic [15:0] PFX_SP = "*p";
  localparam logic [15:0] PFX_SV = "*v";
  localparam logic [15:0] PFX_SG = "*g";
  localparam logic [15:0] PFX_AL = "&l";
  localparam logic [15:0] PFX_SR = "*r";
  localparam logic [15:0] PFX_SO = "*o";
  localparam logic [15:0] PFX_AU = "&u";
  localparam logic [15:0] PFX_PM = "%-";

  // Exact commands: total length and magnitude
  localparam logic [CMD_LEN_W-1:0] UEL_LEN        = 7'd8;
  localparam logic [CMD_LEN_W-1:0] PRELOAD_LEN    = 7'd5;
  localparam logic [CMD_LEN_W-1:0] START_RAST_LEN = 7'd4;
  localparam logic [ARG_W-1:0]     UEL_MAG        = 32'd12345;
  localparam logic [ARG_W-1:0]     PRELOAD_MAG    = 32'd2;
  localparam logic [ARG_W-1:0]     START_RAST_MAG = 32'd1;
  localparam logic [CMD_LEN_W-1:0] END_RAST_IDX   = 7'd3;
  localparam logic [CMD_LEN_W-1:0] RB_MARK_IDX    = 7'd2;

  localparam logic [ARG_W-1:0] MAG_CAP = 32'h8000_0000;
  localparam logic [ARG_W-1:0] POS_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic                   hit;
    logic                   to_data;
    logic [EV_W-1:0]        ev;
    logic signed [ARG_W-1:0] val;
  } match_t;

endpackage

[src/pcl_esc_in_if.sv]
interface pcl_esc_in_if;
  logic                             valid;
  logic                             ready;
  logic [pcl_esc_pkg::BYTE_W-1:0]   in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[src/pcl_esc_out_if.sv]
interface pcl_esc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [pcl_esc_pkg::EV_W-1:0]          event_res;
  logic signed [pcl_esc_pkg::ARG_W-1:0]  argument;
  logic [pcl_esc_pkg::BYTE_W-1:0]        data_byte;
  logic                                  data_last;

  modport source (output valid, output event_res, output argument, output data_byte,
                  output data_last, input ready);
  modport sink (input valid, input event_res, input argument, input data_byte,
                input data_last, output ready);
endinterface

[src/pcl_esc_match.sv]
// Terminator match for a command with a completed number.
module pcl_esc_match (
  input  logic [15:0]                           prefix_i,
  input  logic [pcl_esc_pkg::BYTE_W-1:0]        term_i,
  input  logic                                  neg_i,
  input  logic [pcl_esc_pkg::ARG_W-1:0]         mag_i,
  input  logic [pcl_esc_pkg::CMD_LEN_W-1:0]     len_i,
  output pcl_esc_pkg::match_t                   match_o
);

  logic                             ev_ok;
  logic                             is_data;
  logic [pcl_esc_pkg::EV_W-1:0]     ev;
  logic [pcl_esc_pkg::ARG_W-1:0]    val;
  logic                             val_zero;
  logic                             val_neg;

  always_comb begin
    if (neg_i) begin
      val = -mag_i;
    end else if (mag_i[pcl_esc_pkg::ARG_W-1]) begin
      val = pcl_esc_pkg::POS_MAX;
    end else begin
      val = mag_i;
    end
    val_zero = (mag_i == '0);
    val_neg  = neg_i && !val_zero;
  end

  always_comb begin
    ev_ok   = 1'b0;
    is_data = 1'b0;
    ev      = pcl_esc_pkg::EV_PLANE_HDR;
    if (prefix_i == pcl_esc_pkg::PFX_SB) begin
      if (term_i == pcl_esc_pkg::CH_V) begin
        ev_ok = 1'b1; is_data = 1'b1; ev = pcl_esc_pkg::EV_PLANE_HDR;
      end else if (term_i == pcl_esc_pkg::CH_W) begin
        ev_ok = 1'b1; is_data = 1'b1; ev = pcl_esc_pkg::EV_ROW_HDR;
      end else if (term_i == pcl_esc_pkg::CH_Y) begin
        ev_ok = 1'b1;
        ev    = val_zero ? pcl_esc_pkg::EV_SEED_RESET : pcl_esc_pkg::EV_VMOVE_UNSUP;
      end
    end else if (prefix_i == pcl_esc_pkg::PFX_SP) begin
      ev_ok = (term_i == pcl_esc_pkg::CH_Y);
      ev    = pcl_esc_pkg::EV_GOTO_LINE;
    end else if (prefix_i == pcl_esc_pkg::PFX_PM) begin
      ev_ok = (term_i == pcl_esc_pkg::CH_X) && !neg_i && (mag_i == pcl_esc_pkg::UEL_MAG)
              && (len_i == pcl_esc_pkg::UEL_LEN);
      ev    = pcl_esc_pkg::EV_UEL;
    end else if (prefix_i == pcl_esc_pkg::PFX_SV) begin
      ev_ok = (term_i == pcl_esc_pkg::CH_W); is_data = 1'b1;
      ev    = pcl_esc_pkg::EV_IMG_CFG;
    end else if (prefix_i == pcl_esc_pkg::PFX_SG) begin
      ev_ok = (term_i == pcl_esc_pkg::CH_W); is_data = 1'b1;
      ev    = pcl_esc_pkg::EV_RASTER_CFG;
    end else if (prefix_i == pcl_esc_pkg::PFX_AL) begin
      if (term_i == pcl_esc_pkg::CH_A) begin
        ev_ok = 1'b1; ev = pcl_esc_pkg::EV_MEDIA_SIZE;
      end else if (term_i == pcl_esc_pkg::CH_H && neg_i
                   && mag_i == pcl_esc_pkg::PRELOAD_MAG
                   && len_i == pcl_esc_pkg::PRELOAD_LEN) begin
        ev_ok = 1'b1; ev = pcl_esc_pkg::EV_PRELOAD;
      end else if (term_i == pcl_esc_pkg::CH_M) begin
        ev_ok = 1'b1; ev = pcl_esc_pkg::EV_MEDIA_TYPE;
      end
    end else if (prefix_i == pcl_esc_pkg::PFX_SR) begin
      if (term_i == pcl_esc_pkg::CH_A && !neg_i && mag_i == pcl_esc_pkg::START_RAST_MAG
          && len_i == pcl_esc_pkg::START_RAST_LEN) begin
        ev_ok = 1'b1; ev = pcl_esc_pkg::EV_START_RAST;
      end else if (term_i == pcl_esc_pkg::CH_S) begin
        ev_ok = 1'b1; ev = pcl_esc_pkg::EV_PIX_ROW;
      end
    end else if (prefix_i == pcl_esc_pkg::PFX_SO) begin
      ev_ok = (term_i == pcl_esc_pkg::CH_M);
      ev    = pcl_esc_pkg::EV_QUALITY;
    end else if (prefix_i == pcl_esc_pkg::PFX_AU) begin
      ev_ok = (term_i == pcl_esc_pkg::CH_D);
      ev    = pcl_esc_pkg::EV_XRES;
    end
  end

  // Drop a data header with a negative count
  assign match_o.hit     = ev_ok && !(is_data && val_neg);
  assign match_o.to_data = is_data && !val_neg && !val_zero;
  assign match_o.ev      = ev;
  assign match_o.val     = val;

endmodule

[src/pcl_escape_command_parser_core.sv]
// A result appears on the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; input ready follows the output register, so a held
//   result stalls the input only while the sink holds ready low.
// Reset (rst_ni low, asynchronous): parser returns to idle, command state clears,
//   output register empties.
module pcl_escape_command_parser_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pcl_esc_in_if.sink            in_i,
  pcl_esc_out_if.source         out_o
);

  // Parser state
  pcl_esc_pkg::mode_e                    mode_q, mode_d;
  logic [pcl_esc_pkg::CMD_LEN_W-1:0]     len_q, len_d;
  logic [15:0]                           prefix_q, prefix_d;
  logic [pcl_esc_pkg::ARG_W-1:0]         accum_q, accum_d;
  pcl_esc_pkg::num_flags_t               flags_q, flags_d;
  logic [pcl_esc_pkg::ARG_W-1:0]         data_rem_q, data_rem_d;

  // Output register
  logic                                  out_valid_q, out_valid_d;
  logic [pcl_esc_pkg::EV_W-1:0]          out_ev_q, res_ev;
  logic signed [pcl_esc_pkg::ARG_W-1:0]  out_arg_q, res_arg;
  logic [pcl_esc_pkg::BYTE_W-1:0]        out_byte_q, res_byte;
  logic                                  out_last_q, res_last;
  logic                                  res_valid;

  logic                                  in_acc;
  logic [pcl_esc_pkg::BYTE_W-1:0]        b;
  logic                                  is_digit;
  logic                                  is_ws;
  logic [pcl_esc_pkg::CMD_LEN_W-1:0]     len_inc;
  logic [pcl_esc_pkg::ACC_W-1:0]         acc_wide;
  logic [pcl_esc_pkg::ARG_W-1:0]         accum_next;
  logic [pcl_esc_pkg::ARG_W-1:0]         rem_dec;
  logic                                  known_pfx;
  logic                                  rb_mark;
  pcl_esc_pkg::match_t                   match;

  // Accept a request whenever the output register is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;

  assign is_digit = (b >= pcl_esc_pkg::CH_ZERO) && (b <= pcl_esc_pkg::CH_NINE);
  assign is_ws    = (b == pcl_esc_pkg::CH_SPACE)
                    || ((b >= pcl_esc_pkg::CH_HT) && (b <= pcl_esc_pkg::CH_CR));
  assign len_inc  = len_q + 1'b1;

  // accum * 10 + digit, saturated at 2^31
  assign acc_wide   = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
                      + pcl_esc_pkg::ACC_W'(b[3:0]);
  assign accum_next = (acc_wide > pcl_esc_pkg::ACC_W'(pcl_esc_pkg::MAG_CAP))
                      ? pcl_esc_pkg::MAG_CAP : acc_wide[pcl_esc_pkg::ARG_W-1:0];

  assign rem_dec = (data_rem_q != '0) ? data_rem_q - 1'b1 : data_rem_q;

  // Prefix check on the second character (old high byte, new low byte)
  always_comb begin
    logic [15:0] p;
    p = {prefix_q[15:8], b};
    known_pfx = (p == pcl_esc_pkg::PFX_SB) || (p == pcl_esc_pkg::PFX_SP)
             || (p == pcl_esc_pkg::PFX_SV) || (p == pcl_esc_pkg::PFX_SG)
             || (p == pcl_esc_pkg::PFX_AL) || (p == pcl_esc_pkg::PFX_SR)
             || (p == pcl_esc_pkg::PFX_SO) || (p == pcl_esc_pkg::PFX_AU)
             || (p == pcl_esc_pkg::PFX_PM);
  end

  // "*rb" marks the dead command so that a following 'C' ends the raster
  assign rb_mark = (len_q == pcl_esc_pkg::RB_MARK_IDX) && (prefix_q == pcl_esc_pkg::PFX_SR)
                   && (b == pcl_esc_pkg::CH_LC_B);

  pcl_esc_match u_match (
    .prefix_i (prefix_q),
    .term_i   (b),
    .neg_i    (flags_q.neg),
    .mag_i    (accum_q),
    .len_i    (len_inc),
    .match_o  (match)
  );

  // Next state and result for the accepted byte
  always_comb begin
    mode_d     = mode_q;
    len_d      = len_q;
    prefix_d   = prefix_q;
    accum_d    = accum_q;
    flags_d    = flags_q;
    data_rem_d = data_rem_q;
    res_valid  = 1'b0;
    res_ev     = pcl_esc_pkg::EV_PLANE_HDR;
    res_arg    = '0;
    res_byte   = '0;
    res_last   = 1'b0;

    if (in_acc) begin
      unique case (mode_q)
        pcl_esc_pkg::MODE_CMD: begin
          if (len_q >= pcl_esc_pkg::CMD_LEN_W'(pcl_esc_pkg::CMD_BUF_SIZE - 1)) begin
            // Overflow: drop the byte, even ESC, and go idle
            mode_d = pcl_esc_pkg::MODE_IDLE;
            len_d = '0; prefix_d = '0; accum_d = '0; flags_d = '0;
          end else if (b == pcl_esc_pkg::CH_ESC) begin
            // Restart an empty command
            len_d = '0; prefix_d = '0; accum_d = '0; flags_d = '0;
          end else begin
            len_d = len_inc;
            if (len_q == '0) begin
              if (b == pcl_esc_pkg::CH_E) begin
                mode_d = pcl_esc_pkg::MODE_IDLE;
                len_d = '0; prefix_d = '0; accum_d = '0; flags_d = '0;
                res_valid = 1'b1;
                res_ev    = pcl_esc_pkg::EV_RESET;
              end else begin
                prefix_d = {b, 8'h00};
              end
            end else if (len_q == 7'd1) begin
              prefix_d = {prefix_q[15:8], b};
              if (!known_pfx) begin
                flags_d = '{dead: 1'b1, phase: pcl_esc_pkg::PH_LEAD, neg: 1'b0};
                accum_d = '0;
              end
            end else if (flags_q.dead) begin
              // Collect silently; only "*rbC" still completes
              if (len_q == pcl_esc_pkg::END_RAST_IDX && accum_q == 32'd1
                  && prefix_q == pcl_esc_pkg::PFX_SR && b == pcl_esc_pkg::CH_C) begin
                mode_d = pcl_esc_pkg::MODE_IDLE;
                len_d = '0; prefix_d = '0; accum_d = '0; flags_d = '0;
                res_valid = 1'b1;
                res_ev    = pcl_esc_pkg::EV_END_RASTER;
              end
            end else begin
              unique case (flags_q.phase)
                pcl_esc_pkg::PH_LEAD: begin
                  if (is_ws) begin
                    // skip leading whitespace
                  end else if (b == pcl_esc_pkg::CH_PLUS || b == pcl_esc_pkg::CH_MINUS) begin
                    flags_d = '{dead: 1'b0, phase: pcl_esc_pkg::PH_SIGN,
                                neg: (b == pcl_esc_pkg::CH_MINUS)};
                  end else if (is_digit) begin
                    accum_d = pcl_esc_pkg::ARG_W'(b[3:0]);
                    flags_d = '{dead: 1'b0, phase: pcl_esc_pkg::PH_DIGIT, neg: flags_q.neg};
                  end else begin
                    flags_d = '{dead: 1'b1, phase: pcl_esc_pkg::PH_LEAD, neg: 1'b0};
                    accum_d = pcl_esc_pkg::ARG_W'(rb_mark);
                  end
                end
                pcl_esc_pkg::PH_SIGN: begin
                  if (is_digit) begin
                    accum_d = pcl_esc_pkg::ARG_W'(b[3:0]);
                    flags_d = '{dead: 1'b0, phase: pcl_esc_pkg::PH_DIGIT, neg: flags_q.neg};
                  end else begin
                    flags_d = '{dead: 1'b1, phase: pcl_esc_pkg::PH_LEAD, neg: 1'b0};
                    accum_d = '0;
                  end
                end
                pcl_esc_pkg::PH_DIGIT: begin
                  if (is_digit) begin
                    accum_d = accum_next;
                  end else if (match.hit) begin
                    len_d = '0; prefix_d = '0; accum_d = '0; flags_d = '0;
                    if (match.to_data) begin
                      mode_d     = pcl_esc_pkg::MODE_DATA;
                      data_rem_d = match.val;
                    end else begin
                      mode_d = pcl_esc_pkg::MODE_IDLE;
                    end
                    res_valid = 1'b1;
                    res_ev    = match.ev;
                    res_arg   = match.val;
                  end else begin
                    flags_d = '{dead: 1'b1, phase: pcl_esc_pkg::PH_LEAD, neg: 1'b0};
                    accum_d = '0;
                  end
                end
                default: begin
                  flags_d = '{dead: 1'b1, phase: pcl_esc_pkg::PH_LEAD, neg: 1'b0};
                  accum_d = '0;
                end
              endcase
            end
          end
        end
        pcl_esc_pkg::MODE_DATA: begin
          // Pass the byte through; ESC is payload here
          data_rem_d = rem_dec;
          res_valid  = 1'b1;
          res_ev     = pcl_esc_pkg::EV_DATA_BYTE;
          res_byte   = b;
          res_last   = (rem_dec == '0);
          if (rem_dec == '0) begin
            mode_d = pcl_esc_pkg::MODE_IDLE;
          end
        end
        default: begin
          // Idle: wait for ESC
          if (b == pcl_esc_pkg::CH_ESC) begin
            mode_d = pcl_esc_pkg::MODE_CMD;
            len_d = '0; prefix_d = '0; accum_d = '0; flags_d = '0;
          end
        end
      endcase
    end
  end

  // Load the output register on an accepted request, empty it when drained
  always_comb begin
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pcl_esc_pkg::MODE_IDLE;
      len_q       <= '0;
      prefix_q    <= '0;
      accum_q     <= '0;
      flags_q     <= '0;
      data_rem_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      len_q       <= len_d;
      prefix_q    <= prefix_d;
      accum_q     <= accum_d;
      flags_q     <= flags_d;
      data_rem_q  <= data_rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_ev_q   <= res_ev;
      out_arg_q  <= res_arg;
      out_byte_q <= res_byte;
      out_last_q <= res_last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_ev_q;
  assign out_o.argument  = out_arg_q;
  assign out_o.data_byte = out_byte_q;
  assign out_o.data_last = out_last_q;

  // Checks
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while result stalled");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= pcl_esc_pkg::CMD_LEN_W'(pcl_esc_pkg::CMD_BUF_SIZE - 1))
    else $error("command length beyond buffer");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == pcl_esc_pkg::MODE_DATA |-> data_rem_q != '0)
    else $error("data mode with no bytes left");

  a_last_ends_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_valid && res_last |=> mode_q == pcl_esc_pkg::MODE_IDLE)
    else $error("last data byte did not return to idle");

  a_dead_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.dead |-> flags_q.phase == pcl_esc_pkg::PH_LEAD && !flags_q.neg)
    else $error("dead command carries number state");

endmodule
